// ===== rtl/block_chroma_subsample_roundtrip_top_assert.svh =====
// Assertion macros shared by the block's RTL files.
`ifndef BLOCK_CHROMA_SUBSAMPLE_ROUNDTRIP_TOP_ASSERT_SVH
`define BLOCK_CHROMA_SUBSAMPLE_ROUNDTRIP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define BCSR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bcsr: assertion failed");
// Next-cycle implication, disabled while reset is held.
`define BCSR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bcsr: assertion failed");
`else
`define BCSR_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BCSR_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/bcsr_pkg.sv =====
`timescale 1ns / 1ps
package bcsr_pkg;

    localparam int MAX_BLOCK_SIDE_DEF = 8;
    localparam int SIDE_W = 4;
    localparam int PIX_W = 8;
    localparam int TDATA_W = 24;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd2;

    // forward conversion, 2^16 scale
    localparam int CONV_W = 26;
    localparam logic signed [CONV_W-1:0] Y_R = 26'sd19595;
    localparam logic signed [CONV_W-1:0] Y_G = 26'sd38470;
    localparam logic signed [CONV_W-1:0] Y_B = 26'sd7471;
    localparam logic signed [CONV_W-1:0] Y_BIAS = 26'sd32768;
    localparam logic signed [CONV_W-1:0] CB_R = 26'sd11059;
    localparam logic signed [CONV_W-1:0] CB_G = 26'sd21709;
    localparam logic signed [CONV_W-1:0] CB_B = 26'sd32768;
    localparam logic signed [CONV_W-1:0] CR_R = 26'sd32768;
    localparam logic signed [CONV_W-1:0] CR_G = 26'sd27439;
    localparam logic signed [CONV_W-1:0] CR_B = 26'sd5329;
    localparam logic signed [CONV_W-1:0] C_BIAS = 26'sd8421375;

    // inverse conversion, 2^16 scale
    localparam int PW = 27;
    localparam logic signed [PW-1:0] K_R_CR = 27'sd91881;
    localparam logic signed [PW-1:0] K_G_CB = 27'sd22554;
    localparam logic signed [PW-1:0] K_G_CR = 27'sd46802;
    localparam logic signed [PW-1:0] K_B_CB = 27'sd116130;
    localparam logic signed [PW-1:0] FIX_HALF = 27'sd32768;
    localparam logic [PIX_W:0] CHROMA_MID = 9'd128;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_CONV,
        ST_START,
        ST_DIV,
        ST_PROD,
        ST_TERM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic cfg_write;
        logic pix_load;
        logic pix_commit;
        logic clear;
        logic div_start;
        logic prod_load;
        logic term_load;
        logic emit_start;
    } cmd_t;

    typedef struct packed {
        logic block_full;
        logic div_done;
        logic emit_done;
    } status_t;

    // pixels in a block for a raw side value: zero acts as one, clip at max
    function automatic logic [7:0] block_pixels(input logic [SIDE_W-1:0] side,
                                                input logic [SIDE_W-1:0] max_side);
        logic [SIDE_W-1:0] s;
        s = side;
        if (s == '0) begin
            s = 4'd1;
        end
        if (s > max_side) begin
            s = max_side;
        end
        return {4'b0, s} * {4'b0, s};
    endfunction

    // signed 11.16 value plus rounding -> clamped byte
    function automatic logic [PIX_W-1:0] clamp_px(input logic signed [PW-1:0] acc);
        logic [PIX_W-1:0] v;
        if (acc[PW-1]) begin
            v = '0;
        end else if (acc[PW-2:24] != '0) begin
            v = '1;
        end else begin
            v = acc[23:16];
        end
        return v;
    endfunction

endpackage

// ===== rtl/block_chroma_subsample_roundtrip_top.sv =====
`timescale 1ns / 1ps
// Block chroma subsampling round trip. Pixels of one square block (side set by
// cfg_data, 0 acts as 1, values above MAX_BLOCK_SIDE clip to it) arrive in block
// order; each input transaction is captured, then converted to YCbCr into the
// luma memory and chroma sums before the next one is taken. After the last pixel
// of a block the averaged Cb/Cr come from a shared bit-serial divider (8 quotient
// bits, then a done pulse) between a start state and the product and term states,
// then the block's pixels leave as RGB, up to one per cycle as m_tready allows,
// through a registered memory read and an output register. No input is taken
// while a block drains.
// A register write clears a partially received block.
module block_chroma_subsample_roundtrip_top #(
    parameter int MAX_BLOCK_SIDE = bcsr_pkg::MAX_BLOCK_SIDE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bcsr_pkg::TDATA_W-1:0]  s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bcsr_pkg::TDATA_W-1:0]  m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcsr_pkg::SIDE_W-1:0]   cfg_data
);
    import bcsr_pkg::*;

    cmd_t    cmd;
    status_t status;

    bcsr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bcsr_datapath #(
        .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/bcsr_div.sv =====
`timescale 1ns / 1ps
module bcsr_div #(
    parameter int SUM_W = 14,
    parameter int CW = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [SUM_W-1:0]             dividend_b,
    input  logic [SUM_W-1:0]             dividend_r,
    input  logic [CW-1:0]                divisor,
    output logic [bcsr_pkg::PIX_W-1:0]   quot_b,
    output logic [bcsr_pkg::PIX_W-1:0]   quot_r,
    output logic                         done
);
    import bcsr_pkg::*;

    localparam int STEP_W = $clog2(PIX_W);

    logic [SUM_W-1:0]  rem_b_reg, rem_b_next;
    logic [SUM_W-1:0]  rem_r_reg, rem_r_next;
    logic [SUM_W-1:0]  dsh_reg;
    logic [PIX_W-1:0]  q_b_reg, q_r_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge_b, ge_r;

    // one quotient bit per cycle for both chroma lanes, shared divisor shifter
    always_comb begin
        ge_b = (rem_b_reg >= dsh_reg);
        ge_r = (rem_r_reg >= dsh_reg);
        rem_b_next = ge_b ? (rem_b_reg - dsh_reg) : rem_b_reg;
        rem_r_next = ge_r ? (rem_r_reg - dsh_reg) : rem_r_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(PIX_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_b_reg <= dividend_b;
            rem_r_reg <= dividend_r;
            dsh_reg   <= SUM_W'({divisor, (PIX_W - 1)'(0)});
        end else if (busy_reg) begin
            rem_b_reg <= rem_b_next;
            rem_r_reg <= rem_r_next;
            dsh_reg   <= dsh_reg >> 1;
            q_b_reg   <= {q_b_reg[PIX_W-2:0], ge_b};
            q_r_reg   <= {q_r_reg[PIX_W-2:0], ge_r};
        end
    end

    assign quot_b = q_b_reg;
    assign quot_r = q_r_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/bcsr_datapath.sv =====
`timescale 1ns / 1ps
`include "block_chroma_subsample_roundtrip_top_assert.svh"
module bcsr_datapath #(
    parameter int MAX_BLOCK_SIDE = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bcsr_pkg::cmd_t                  cmd,
    output bcsr_pkg::status_t               status,
    input  logic [bcsr_pkg::SIDE_W-1:0]     cfg_data,
    input  logic [bcsr_pkg::TDATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bcsr_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tlast
);
    import bcsr_pkg::*;

    localparam int DEPTH = MAX_BLOCK_SIDE * MAX_BLOCK_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SUM_W = PIX_W + AW;

    // block size and input side
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     pix_cnt_reg;
    logic [SUM_W-1:0]  sum_b_reg, sum_r_reg;
    logic [TDATA_W-1:0] pix_reg;
    logic [PIX_W-1:0]  luma_mem [DEPTH];

    logic signed [CONV_W-1:0] rs, gs, bs;
    logic signed [CONV_W-1:0] y_full, cb_full, cr_full;
    logic [PIX_W-1:0]  y_px, cb_px, cr_px;

    // divider and chroma terms
    logic [SUM_W-1:0]  div_b_in, div_r_in;
    logic [PIX_W-1:0]  avg_b, avg_r;
    logic              div_done;
    logic signed [PIX_W:0]  d_b, d_r;
    logic signed [PW-1:0]   p_r_reg, p_gb_reg, p_gr_reg, p_b_reg, g_term_reg;

    // emission pipeline
    logic              emit_act_reg;
    logic [CW-1:0]     rd_cnt_reg;
    logic [CW-1:0]     out_cnt_reg;
    logic              rd_en, rd_last, adv2;
    logic              v1_reg;
    logic              last1_reg;
    logic [PIX_W-1:0]  y_q_reg;
    logic              mv_reg;
    logic              mlast_reg;
    logic [TDATA_W-1:0] mdata_reg;
    logic signed [PW-1:0] y_fix;

    always_comb begin
        rs = $signed({18'b0, pix_reg[7:0]});
        gs = $signed({18'b0, pix_reg[15:8]});
        bs = $signed({18'b0, pix_reg[23:16]});
        y_full  = Y_R * rs + Y_G * gs + Y_B * bs + Y_BIAS;
        cb_full = C_BIAS + CB_B * bs - CB_R * rs - CB_G * gs;
        cr_full = C_BIAS + CR_R * rs - CR_G * gs - CR_B * bs;
        y_px  = y_full[23:16];
        cb_px = cb_full[23:16];
        cr_px = cr_full[23:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= CW'(block_pixels(SIDE_RESET, SIDE_W'(MAX_BLOCK_SIDE)));
            pix_cnt_reg <= '0;
            sum_b_reg   <= '0;
            sum_r_reg   <= '0;
        end else if (cmd.cfg_write) begin
            n_reg       <= CW'(block_pixels(cfg_data, SIDE_W'(MAX_BLOCK_SIDE)));
            pix_cnt_reg <= '0;
            sum_b_reg   <= '0;
            sum_r_reg   <= '0;
        end else if (cmd.clear) begin
            pix_cnt_reg <= '0;
            sum_b_reg   <= '0;
            sum_r_reg   <= '0;
        end else if (cmd.pix_commit) begin
            pix_cnt_reg <= pix_cnt_reg + 1'b1;
            sum_b_reg   <= sum_b_reg + SUM_W'(cb_px);
            sum_r_reg   <= sum_r_reg + SUM_W'(cr_px);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_load) begin
            pix_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_commit) begin
            luma_mem[pix_cnt_reg[AW-1:0]] <= y_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            y_q_reg <= luma_mem[rd_cnt_reg[AW-1:0]];
        end
    end

    // round half up: add n/2 before the divide
    assign div_b_in = sum_b_reg + SUM_W'(n_reg >> 1);
    assign div_r_in = sum_r_reg + SUM_W'(n_reg >> 1);

    bcsr_div #(
        .SUM_W (SUM_W),
        .CW    (CW)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.div_start),
        .dividend_b (div_b_in),
        .dividend_r (div_r_in),
        .divisor    (n_reg),
        .quot_b     (avg_b),
        .quot_r     (avg_r),
        .done       (div_done)
    );

    assign d_b = $signed({1'b0, avg_b}) - $signed(CHROMA_MID);
    assign d_r = $signed({1'b0, avg_r}) - $signed(CHROMA_MID);

    always_ff @(posedge aclk) begin
        if (cmd.prod_load) begin
            p_r_reg  <= K_R_CR * PW'(d_r);
            p_gb_reg <= K_G_CB * PW'(d_b);
            p_gr_reg <= K_G_CR * PW'(d_r);
            p_b_reg  <= K_B_CB * PW'(d_b);
        end
        if (cmd.term_load) begin
            g_term_reg <= -p_gb_reg - p_gr_reg;
        end
    end

    // two-stage read: memory data register, then output register
    assign adv2    = !mv_reg || m_tready;
    assign rd_en   = emit_act_reg && (!v1_reg || adv2);
    assign rd_last = (rd_cnt_reg == n_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_act_reg <= 1'b0;
            rd_cnt_reg   <= '0;
            out_cnt_reg  <= '0;
            v1_reg       <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            if (cmd.emit_start) begin
                emit_act_reg <= 1'b1;
                rd_cnt_reg   <= '0;
                out_cnt_reg  <= '0;
            end else begin
                if (rd_en) begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_last) begin
                        emit_act_reg <= 1'b0;
                    end
                end
                if (mv_reg && m_tready) begin
                    out_cnt_reg <= out_cnt_reg + 1'b1;
                end
            end
            if (rd_en) begin
                v1_reg <= 1'b1;
            end else if (adv2) begin
                v1_reg <= 1'b0;
            end
            if (adv2) begin
                mv_reg <= v1_reg;
            end
        end
    end

    assign y_fix = $signed({3'b0, y_q_reg, 16'b0});

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            last1_reg <= rd_last;
        end
        if (adv2 && v1_reg) begin
            mlast_reg <= last1_reg;
            mdata_reg <= {clamp_px(y_fix + p_b_reg + FIX_HALF),
                          clamp_px(y_fix + g_term_reg + FIX_HALF),
                          clamp_px(y_fix + p_r_reg + FIX_HALF)};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    assign status.block_full = (pix_cnt_reg + 1'b1 == n_reg);
    assign status.div_done   = div_done;
    assign status.emit_done  = mv_reg && m_tready && mlast_reg;

    `BCSR_ASSERT_IMP(a_last_count, aclk, aresetn, mv_reg && m_tready && mlast_reg, out_cnt_reg == n_reg - 1'b1)
    `BCSR_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, pix_cnt_reg <= n_reg)
    `BCSR_ASSERT_IMP(a_out_bound, aclk, aresetn, mv_reg, out_cnt_reg < n_reg)

endmodule

// ===== rtl/bcsr_ctrl.sv =====
`timescale 1ns / 1ps
`include "block_chroma_subsample_roundtrip_top_assert.svh"
module bcsr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bcsr_pkg::status_t   status,
    output bcsr_pkg::cmd_t      cmd
);
    import bcsr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT: begin
                if (s_tvalid && s_tready) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                state_next = status.block_full ? ST_START : ST_ACCEPT;
            end
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: state_next = ST_TERM;
            ST_TERM: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.emit_done) begin
                    state_next = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // a register write takes precedence over a pixel in the same cycle
    always_comb begin
        cfg_ready = (state_reg == ST_ACCEPT);
        s_tready  = (state_reg == ST_ACCEPT) && !cfg_valid;
        cmd            = '0;
        cmd.cfg_write  = cfg_valid && cfg_ready;
        cmd.pix_load   = s_tvalid && s_tready;
        cmd.pix_commit = (state_reg == ST_CONV);
        cmd.clear      = (state_reg == ST_START);
        cmd.div_start  = (state_reg == ST_START);
        cmd.prod_load  = (state_reg == ST_PROD);
        cmd.term_load  = (state_reg == ST_TERM);
        cmd.emit_start = (state_reg == ST_TERM);
    end

    `BCSR_ASSERT_NXT(a_accept_conv, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_CONV)
    `BCSR_ASSERT_NXT(a_full_start, aclk, aresetn, state_reg == ST_CONV && status.block_full, state_reg == ST_START)
    `BCSR_ASSERT_NXT(a_emit_back, aclk, aresetn, state_reg == ST_EMIT && status.emit_done, state_reg == ST_ACCEPT)

endmodule
